>>> hw/rtl/b2ad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2ad_pkg: shared definitions for the binary to ASCII decimal display
// Widths, display constants, the converter interface types and the
// character formatting functions.
// ----------------------------------------------------------------------------
package b2ad_pkg;

    // Input word width and the step counter that walks its bits.
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned CNT_W   = $clog2(VALUE_W);

    // Five BCD digits hold any 16-bit value exactly.
    localparam int unsigned BCD_DIGITS = 5;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

    // Digits kept by the display (2 to 5) and character positions shown.
    localparam int unsigned DIGITS = 4;
    localparam int unsigned SHOWN  = 4;

    localparam int unsigned CHAR_W = 7;

    localparam logic [VALUE_W-1:0] INVALID_MARK = 16'hFFFF;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_SPACE  = 7'd32;
    localparam logic [CHAR_W-1:0]  ASCII_DASH   = 7'd45;

    typedef struct packed {
        logic busy;
        logic done;
    } b2ad_stat_t;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             invalid;
    } b2ad_res_t;

    // Character for decimal position k (0 is ones). Leading zeros blank
    // against the full five-digit conversion, which is exact.
    function automatic logic [CHAR_W-1:0] format_char(
        input logic [BCD_W-1:0] bcd,
        input int unsigned      k,
        input logic             invalid
    );
        logic            lead;
        logic [3:0]      dig;
        logic [CHAR_W-1:0] ch;
        lead = 1'b0;
        dig  = bcd[4*k +: 4];
        for (int unsigned j = 0; j < BCD_DIGITS; j++) begin
            if (j >= k && bcd[4*j +: 4] != 4'd0) begin
                lead = 1'b1;
            end
        end
        if (k >= DIGITS) begin
            ch = ASCII_SPACE;
        end else if (invalid) begin
            ch = ASCII_DASH;
        end else if (k > 0 && !lead) begin
            ch = ASCII_SPACE;
        end else begin
            ch = ASCII_ZERO + {3'b000, dig};
        end
        return ch;
    endfunction

    // The value needs more digits than the display keeps.
    function automatic logic over_range(
        input logic [BCD_W-1:0] bcd,
        input logic             invalid
    );
        logic ovf;
        ovf = 1'b0;
        for (int unsigned j = 0; j < BCD_DIGITS; j++) begin
            if (j >= DIGITS && bcd[4*j +: 4] != 4'd0) begin
                ovf = 1'b1;
            end
        end
        return ovf && !invalid;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/b2ad_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2ad_dabble: bit-serial binary to BCD converter
// Shift-add-3 conversion that moves one input bit into the BCD register
// per cycle and holds the finished digits until the consumer takes them.
// ----------------------------------------------------------------------------
module b2ad_dabble (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire [b2ad_pkg::VALUE_W-1:0]  value,
    input  wire                          take,
    output b2ad_pkg::b2ad_stat_t         stat,
    output b2ad_pkg::b2ad_res_t          res
);
    import b2ad_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               inv_reg, inv_next;
    logic [BCD_W-1:0]   bcd_adj;

    // Every digit of five or more gets three added before the shift.
    always_comb begin
        for (int unsigned i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        inv_next   = inv_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    bin_next   = value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    inv_next   = (value == INVALID_MARK);
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (take) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        inv_reg <= inv_next;
    end

    assign stat.busy   = (state_reg == ST_SHIFT);
    assign stat.done   = (state_reg == ST_DONE);
    assign res.bcd     = bcd_reg;
    assign res.invalid = inv_reg;

endmodule
`default_nettype wire

>>> hw/rtl/binary_to_ascii_decimal_display_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_display_top: 16-bit value to four ASCII digits
// Converts an unsigned word to decimal and formats it for a character
// display with leading-zero blanking, an invalid marker and overflow flag.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (s_valid, s_ready, s_value) takes one 16-bit word when
// the converter is free. The result channel (m_valid, m_ready) presents the
// four characters, most significant first, and the overflow flag.
// Each word is converted by a shift-add-3 loop that moves one input bit per
// cycle; the finished digits pass into the output register, and a new word
// is taken only once the converter has handed the last one on.
// The value 0xFFFF shows as four dashes. Values above 9999 show their low
// four digits and raise m_overflow.
// The result sits in an output register; while the receiver stalls, the
// next word can still be accepted and converted, and it waits in the
// converter until the output register frees up.
// A synchronous active-low reset empties both the converter and the output
// register; there is no other state to clear.
// ----------------------------------------------------------------------------
module binary_to_ascii_decimal_display_top (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [b2ad_pkg::VALUE_W-1:0]       s_value,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [b2ad_pkg::CHAR_W-1:0]        m_char_thousands,
    output logic [b2ad_pkg::CHAR_W-1:0]        m_char_hundreds,
    output logic [b2ad_pkg::CHAR_W-1:0]        m_char_tens,
    output logic [b2ad_pkg::CHAR_W-1:0]        m_char_ones,
    output logic                               m_overflow
);
    import b2ad_pkg::*;

    b2ad_stat_t        stat;
    b2ad_res_t         res;
    logic              take;

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] thou_reg, hund_reg, tens_reg, ones_reg;
    logic              ovf_reg;

    assign s_ready = !stat.busy && !stat.done;

    // The finished word moves out once the output register is free.
    assign take = stat.done && (!m_valid_reg || m_ready);

    b2ad_dabble u_dabble (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (s_valid && s_ready),
        .value   (s_value),
        .take    (take),
        .stat    (stat),
        .res     (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (take) begin
            thou_reg <= format_char(res.bcd, 3, res.invalid);
            hund_reg <= format_char(res.bcd, 2, res.invalid);
            tens_reg <= format_char(res.bcd, 1, res.invalid);
            ones_reg <= format_char(res.bcd, 0, res.invalid);
            ovf_reg  <= over_range(res.bcd, res.invalid);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_char_thousands = thou_reg;
    assign m_char_hundreds  = hund_reg;
    assign m_char_tens      = tens_reg;
    assign m_char_ones      = ones_reg;
    assign m_overflow       = ovf_reg;

`ifndef ASSERT_OFF
    // An accepted word always starts the shift loop on the next cycle.
    a_start_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> stat.busy)
        else $error("accepted word did not start conversion");

    // A word never moves out of the converter before it is finished.
    a_take_done: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> !stat.busy && $past(stat.busy || stat.done))
        else $error("result taken from an unfinished conversion");

    // The ones position is never blanked.
    a_ones_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_char_ones != ASCII_SPACE)
        else $error("ones digit blanked");

    // The invalid marker never comes with an overflow.
    a_dash_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_char_ones == ASCII_DASH |-> !m_overflow)
        else $error("overflow raised for the invalid marker");
`endif

endmodule
`default_nettype wire

>>> tb/binary_to_ascii_decimal_display_top_tb.sv
// ----------------------------------------------------------------------------
// binary_to_ascii_decimal_display_top_tb: self-checking bench for the display
// Sends 16-bit values through the valid/ready input channel and checks every
// result word (four ASCII characters and the overflow flag) against a local
// predictor of the decimal formatting, in order of acceptance.
// ----------------------------------------------------------------------------
module binary_to_ascii_decimal_display_top_tb;

    import b2ad_pkg::*;

    localparam logic [VALUE_W-1:0] SENTINEL = 16'hFFFF;
    localparam logic [CHAR_W-1:0]  CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0]  CH_SPACE = 7'd32;
    localparam logic [CHAR_W-1:0]  CH_DASH  = 7'd45;

    localparam int unsigned IDLE_PCT    = 17;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_PRINTS  = 30;

    typedef struct packed {
        logic [CHAR_W-1:0] thousands;
        logic [CHAR_W-1:0] hundreds;
        logic [CHAR_W-1:0] tens;
        logic [CHAR_W-1:0] ones;
        logic              overflow;
    } display_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [CHAR_W-1:0]  m_char_thousands;
    logic [CHAR_W-1:0]  m_char_hundreds;
    logic [CHAR_W-1:0]  m_char_tens;
    logic [CHAR_W-1:0]  m_char_ones;
    logic               m_overflow;

    display_t    pending_displays[$];
    bit          no_idle = 1'b0;
    int unsigned words_sent = 0;
    int unsigned words_checked = 0;
    int unsigned overflow_seen = 0;
    int unsigned invalid_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;

    binary_to_ascii_decimal_display_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_char_thousands (m_char_thousands),
        .m_char_hundreds  (m_char_hundreds),
        .m_char_tens      (m_char_tens),
        .m_char_ones      (m_char_ones),
        .m_overflow       (m_overflow)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Expected display for one value: leading zeros blank against the whole
    // value, so dropped high digits never count as leading digits.
    function automatic display_t display_of(input logic [VALUE_W-1:0] v);
        int unsigned       nd;
        int unsigned       rest;
        int unsigned       weight;
        int unsigned       k;
        logic [19:0]       bcd;
        logic [CHAR_W-1:0] ch;
        logic              bad;
        display_t          d;
        nd = b2ad_pkg::DIGITS;
        if (nd < 1) nd = 1;
        if (nd > 5) nd = 5;
        bad = (v == SENTINEL);
        rest = 32'(v);
        for (k = 0; k < 5; k++) begin
            bcd[4*k +: 4] = 4'(rest % 10);
            rest = rest / 10;
        end
        weight = 1;
        for (k = 0; k < 4; k++) begin
            if (k >= nd) begin
                ch = CH_SPACE;
            end else if (bad) begin
                ch = CH_DASH;
            end else if (k > 0 && v < weight) begin
                ch = CH_SPACE;
            end else begin
                ch = CH_ZERO + {3'b000, bcd[4*k +: 4]};
            end
            case (k)
                0: d.ones = ch;
                1: d.tens = ch;
                2: d.hundreds = ch;
                default: d.thousands = ch;
            endcase
            weight = weight * 10;
        end
        weight = 1;
        for (k = 0; k < nd; k++) weight = weight * 10;
        d.overflow = !bad && (v >= weight);
        return d;
    endfunction

    // Values clustered where the formatting changes, plus plain noise.
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_value = 16'($urandom_range(0, 9999));
            4: pick_value = 16'($urandom_range(0, 99));
            5: begin
                case ($urandom_range(0, 4))
                    0: p = 1;
                    1: p = 10;
                    2: p = 100;
                    3: p = 1000;
                    default: p = 10000;
                endcase
                pick_value = 16'(p - 1 + $urandom_range(0, 2));
            end
            6: pick_value = SENTINEL;
            7: pick_value = 16'(32'hFFFE - $urandom_range(0, 5));
            default: pick_value = 16'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch at word %0d: %s got 0x%0h, expected 0x%0h",
                     words_checked, what, got, want);
        end
    endtask

    // Drives one word and returns at the edge where it is accepted.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            s_value <= 16'($urandom);
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    always @(posedge aclk) begin
        m_ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pending_displays.push_back(display_of(s_value));
        end
    end

    always @(posedge aclk) begin
        display_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_displays.size() == 0) begin
                report_mismatch("unexpected word", m_overflow, 0);
            end else begin
                want = pending_displays.pop_front();
                if (m_char_thousands !== want.thousands)
                    report_mismatch("thousands", m_char_thousands, want.thousands);
                if (m_char_hundreds !== want.hundreds)
                    report_mismatch("hundreds", m_char_hundreds, want.hundreds);
                if (m_char_tens !== want.tens)
                    report_mismatch("tens", m_char_tens, want.tens);
                if (m_char_ones !== want.ones)
                    report_mismatch("ones", m_char_ones, want.ones);
                if (m_overflow !== want.overflow)
                    report_mismatch("overflow", m_overflow, want.overflow);
                if (want.overflow) overflow_seen++;
                if (want.ones == CH_DASH) invalid_seen++;
            end
            words_checked++;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_displays.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_blanking();
        send_value(16'd0);
        send_value(16'd1);
        send_value(16'd9);
        send_value(16'd10);
        send_value(16'd99);
        send_value(16'd100);
        send_value(16'd999);
        send_value(16'd1000);
        send_value(16'd4321);
        send_value(16'd9999);
        send_value(16'h5555);
    endtask

    task automatic test_overflow();
        send_value(16'd10000);
        send_value(16'd10005);
        send_value(16'd12345);
        send_value(16'hAAAA);
        send_value(16'd65534);
    endtask

    task automatic test_invalid();
        send_value(SENTINEL);
        send_value(SENTINEL);
        send_value(16'd7);
    endtask

    task automatic test_random_with_idling(input int unsigned count);
        repeat (count) send_value(pick_value());
    endtask

    // Full-rate stretch: the sender never pauses and the receiver never stalls.
    task automatic test_back_to_back(input int unsigned count);
        no_idle = 1'b1;
        repeat (count) send_value(pick_value());
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_blanking();
        test_overflow();
        test_invalid();
        test_random_with_idling(1000);
        test_back_to_back(600);
        test_random_with_idling(30);

        s_valid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("sent %0d words, checked %0d results in %0d cycles",
                 words_sent, words_checked, cycles);
        $display("including %0d overflowed and %0d invalid readings, %0d mismatches",
                 overflow_seen, invalid_seen, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
